/* hw/rtl/knn_pkg.sv */
// Package for the k-nearest-neighbor search block: widths, codes, state type.
// Used by every module of the block; depends on nothing.
package knn_pkg;

  localparam int DefMaxRows       = 256;
  localparam int DefMaxDims       = 256;
  localparam int DefMaxNeighbours = 16;

  localparam int DistW = 40;
  localparam int ValW  = 16;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [1:0] {
    CMD_TARGET = 2'd0,
    CMD_ROW    = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_NEIGHBOURS = 2'd0,
    REG_ROWS       = 2'd1,
    REG_DIMS       = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_INSERT,
    ST_EMIT
  } state_e;

endpackage

/* hw/rtl/knn_dist_unit.sv */
// Shared squared-difference accumulate unit, one element per cycle.
// Depends on knn_pkg.
module knn_dist_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     clear_i,
  input  logic                     valid_i,
  input  logic [knn_pkg::ValW-1:0] a_i,
  input  logic [knn_pkg::ValW-1:0] b_i,
  output logic [knn_pkg::DistW-1:0] acc_o,
  output logic                     busy_o
);

  logic [knn_pkg::ValW-1:0]   diff_q, diff_d;
  logic                       sq_vld_q, dif_vld_q;
  logic [2*knn_pkg::ValW-1:0] sq_q;
  logic [knn_pkg::DistW-1:0]  acc_q, acc_d;
  logic [knn_pkg::DistW:0]    sum;

  // Absolute difference.
  assign diff_d = (a_i >= b_i) ? (a_i - b_i) : (b_i - a_i);

  // Saturating accumulate.
  always_comb begin
    sum = {1'b0, acc_q} + {{(knn_pkg::DistW + 1 - 2*knn_pkg::ValW){1'b0}}, sq_q};
    if (sum[knn_pkg::DistW]) begin
      acc_d = knn_pkg::DistMax;
    end else begin
      acc_d = sum[knn_pkg::DistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_vld_q <= 1'b0;
      sq_vld_q  <= 1'b0;
    end else begin
      dif_vld_q <= valid_i;
      sq_vld_q  <= dif_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= diff_q * diff_q;
    if (clear_i) begin
      acc_q <= '0;
    end else if (sq_vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = dif_vld_q | sq_vld_q;

endmodule

/* hw/rtl/knn_search.sv */
// Knn_euclidean_search top level. Depends on knn_pkg and knn_dist_unit.
// Target and database memories live here; a sequencer drives the shared unit.
//
// Load words (cmd 0 and 1) are taken and the block stays ready.
// A search word keeps the block busy: the shared squared-difference unit
// handles one element a cycle, its pipeline drains, and each row then
// walks the sorted list for its insert position. Results go out one per
// cycle while the block is not ready and m_axis_tready is high. No
// clearing pass is needed: the stores are undefined until written.

/* hw/rtl/knn_euclidean_search.sv */
// Top level of the k-nearest-neighbor search block; holds the stores,
// sequencer and sorted list. Depends on knn_pkg and knn_dist_unit.
//
// A load word (cmd 0 or 1) is taken and the block stays idle. A search word
// keeps s_axis_tready low while the shared squared-difference unit takes
// one element per cycle from the row memory, its pipeline drains, and each
// finished row then walks the sorted list one entry a cycle to find its
// place. The min(k, rows) results then leave one per cycle through the
// output register while m_axis_tready is high, nearest first, tlast on the
// final one.
module knn_euclidean_search #(
  parameter int MAX_ROWS       = knn_pkg::DefMaxRows,
  parameter int MAX_DIMS       = knn_pkg::DefMaxDims,
  parameter int MAX_NEIGHBOURS = knn_pkg::DefMaxNeighbours
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: cmd[1:0], row_index[9:2], dim_index[17:10], element_value[33:18]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rank[3:0], match_row[11:4], match_distance_sq[51:12]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int KW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
  localparam int KCW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int AW = $clog2(MAX_ROWS * MAX_DIMS);
  localparam int DistW = knn_pkg::DistW;

  // Input fields.
  logic [1:0]  in_cmd;
  logic [7:0]  in_row, in_dim;
  logic [15:0] in_val;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[9:2];
  assign in_dim = s_axis_tdata[17:10];
  assign in_val = s_axis_tdata[33:18];

  // Configuration registers.
  logic [4:0] neigh_q;
  logic [8:0] rows_q, dims_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neigh_q <= 5'd1;
      rows_q  <= 9'd256;
      dims_q  <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        knn_pkg::REG_NEIGHBOURS: neigh_q <= cfg_data_i[4:0];
        knn_pkg::REG_ROWS:       rows_q  <= cfg_data_i;
        knn_pkg::REG_DIMS:       dims_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamped limits.
  logic [KCW-1:0] k_lim;
  logic [RCW-1:0] rows_lim;
  logic [DCW-1:0] dims_lim;
  always_comb begin
    if (neigh_q == 5'd0) k_lim = KCW'(1);
    else if (32'(neigh_q) > MAX_NEIGHBOURS) k_lim = KCW'(MAX_NEIGHBOURS);
    else k_lim = KCW'(neigh_q);
    if (rows_q == 9'd0) rows_lim = RCW'(1);
    else if (32'(rows_q) > MAX_ROWS) rows_lim = RCW'(MAX_ROWS);
    else rows_lim = RCW'(rows_q);
    if (dims_q == 9'd0) dims_lim = DCW'(1);
    else if (32'(dims_q) > MAX_DIMS) dims_lim = DCW'(MAX_DIMS);
    else dims_lim = DCW'(dims_q);
  end

  knn_pkg::state_e state_q, state_d;
  logic in_acc;
  assign s_axis_tready = (state_q == knn_pkg::ST_IDLE) && !m_axis_tvalid;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Memories.
  logic [15:0] db_mem [MAX_ROWS*MAX_DIMS];
  logic [15:0] tg_mem [MAX_DIMS];
  logic [15:0] db_rd_q, tg_rd_q;
  logic [RW-1:0] row_q, row_d;
  logic [DW-1:0] dim_q, dim_d;
  logic          rd_en;
  logic          rd_vld_q;

  logic in_row_ok, in_dim_ok;
  assign in_row_ok = 32'(in_row) < MAX_ROWS;
  assign in_dim_ok = 32'(in_dim) < MAX_DIMS;

  // Row-major addresses into the database memory.
  logic [AW-1:0] wr_addr, rd_addr;
  assign wr_addr = AW'(32'(in_row) * MAX_DIMS + 32'(in_dim));
  assign rd_addr = AW'(32'(row_q) * MAX_DIMS + 32'(dim_q));

  always_ff @(posedge clk_i) begin
    if (in_acc && in_cmd == knn_pkg::CMD_ROW && in_row_ok && in_dim_ok) begin
      db_mem[wr_addr] <= in_val;
    end
    if (in_acc && in_cmd == knn_pkg::CMD_TARGET && in_dim_ok) begin
      tg_mem[DW'(in_dim)] <= in_val;
    end
    if (rd_en) begin
      db_rd_q <= db_mem[rd_addr];
      tg_rd_q <= tg_mem[dim_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rd_vld_q <= 1'b0;
    else rd_vld_q <= rd_en;
  end

  // Shared distance unit.
  logic             dist_clear, dist_busy;
  logic [DistW-1:0] dist_acc;
  knn_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (dist_clear),
    .valid_i (rd_vld_q),
    .a_i     (db_rd_q),
    .b_i     (tg_rd_q),
    .acc_o   (dist_acc),
    .busy_o  (dist_busy)
  );

  // Sorted list.
  logic [DistW-1:0] best_d_q [MAX_NEIGHBOURS];
  logic [RW-1:0]    best_r_q [MAX_NEIGHBOURS];
  logic [KCW-1:0]   filled_q, filled_d;
  logic [KCW-1:0]   pos_q, pos_d;
  logic             last_row_q, last_row_d;
  logic             ins_en;

  logic pos_go;
  assign pos_go = (pos_q < filled_q) && (best_d_q[KW'(pos_q)] <= dist_acc);

  always_ff @(posedge clk_i) begin
    if (ins_en) begin
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
        if (KCW'(i) > pos_q && KCW'(i) < filled_d) begin
          best_d_q[i] <= best_d_q[(i > 0) ? i - 1 : 0];
          best_r_q[i] <= best_r_q[(i > 0) ? i - 1 : 0];
        end else if (KCW'(i) == pos_q) begin
          best_d_q[i] <= dist_acc;
          best_r_q[i] <= row_q;
        end
      end
    end
  end

  // Output register.
  logic             out_vld_q, out_vld_d, out_load;
  logic [KCW-1:0]   emit_q, emit_d;
  logic [3:0]       o_rank_q;
  logic [7:0]       o_row_q;
  logic [DistW-1:0] o_dist_q;
  logic             o_last_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_rank_q <= 4'(emit_q);
      o_row_q  <= 8'(best_r_q[KW'(emit_q)]);
      o_dist_q <= best_d_q[KW'(emit_q)];
      o_last_q <= (emit_q + KCW'(1)) == filled_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, o_dist_q, o_row_q, o_rank_q};
  assign m_axis_tlast  = o_last_q;

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= knn_pkg::ST_IDLE;
      row_q      <= '0;
      dim_q      <= '0;
      filled_q   <= '0;
      pos_q      <= '0;
      emit_q     <= '0;
      out_vld_q  <= 1'b0;
      last_row_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      dim_q      <= dim_d;
      filled_q   <= filled_d;
      pos_q      <= pos_d;
      emit_q     <= emit_d;
      out_vld_q  <= out_vld_d;
      last_row_q <= last_row_d;
    end
  end

  // Next state and controls.
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    dim_d      = dim_q;
    filled_d   = filled_q;
    pos_d      = pos_q;
    emit_d     = emit_q;
    last_row_d = last_row_q;
    rd_en      = 1'b0;
    dist_clear = 1'b0;
    ins_en     = 1'b0;
    out_load   = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready;
    case (state_q)
      knn_pkg::ST_IDLE: begin
        if (in_acc && in_cmd == knn_pkg::CMD_SEARCH) begin
          state_d    = knn_pkg::ST_DIST;
          row_d      = '0;
          dim_d      = '0;
          filled_d   = '0;
          dist_clear = 1'b1;
          last_row_d = rows_lim == RCW'(1);
        end
      end
      knn_pkg::ST_DIST: begin
        rd_en = 1'b1;
        if ((DCW'(dim_q) + DCW'(1)) == dims_lim) begin
          dim_d   = '0;
          state_d = knn_pkg::ST_DRAIN;
        end else begin
          dim_d = dim_q + DW'(1);
        end
      end
      knn_pkg::ST_DRAIN: begin
        if (!rd_vld_q && !dist_busy) begin
          pos_d   = '0;
          state_d = knn_pkg::ST_INSERT;
        end
      end
      knn_pkg::ST_INSERT: begin
        if (pos_go) begin
          pos_d = pos_q + KCW'(1);
        end else begin
          if (pos_q < k_lim) begin
            ins_en = 1'b1;
            if (filled_q < k_lim) filled_d = filled_q + KCW'(1);
          end
          dist_clear = 1'b1;
          if (last_row_q) begin
            emit_d  = '0;
            state_d = knn_pkg::ST_EMIT;
          end else begin
            row_d      = row_q + RW'(1);
            last_row_d = (RCW'(row_q) + RCW'(2)) == rows_lim;
            state_d    = knn_pkg::ST_DIST;
          end
        end
      end
      knn_pkg::ST_EMIT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          emit_d    = emit_q + KCW'(1);
          if ((emit_q + KCW'(1)) == filled_q) state_d = knn_pkg::ST_IDLE;
        end
      end
      default: state_d = knn_pkg::ST_IDLE;
    endcase
  end

  // The padding bits of the input word carry nothing.
  logic unused_ok;
  assign unused_ok = |s_axis_tdata[39:34];

  // Checks.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= KCW'(MAX_NEIGHBOURS)) else $error("list overfilled");
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != knn_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(o_dist_q)))
    else $error("result dropped");
  a_search_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_cmd == knn_pkg::CMD_SEARCH) |=> (state_q == knn_pkg::ST_DIST))
    else $error("search not started");

endmodule

/* dv/knn_search_checker.sv */
`timescale 1ns / 1ps
// Checker for the k-nearest-neighbor search block: watches the load, search,
// configuration and result channels, predicts results and compares them.
// Depends on knn_pkg for the command and register codes.
module knn_search_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata: cmd[1:0], row_index[9:2], dim_index[17:10], element_value[33:18]
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: rank[3:0], match_row[11:4], match_distance_sq[51:12]
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          mismatch_count,
  output int          pending_count
);

  typedef struct packed {
    logic [3:0]                rank;
    logic [7:0]                row;
    logic [knn_pkg::DistW-1:0] dist_sq;
    logic                      last;
  } neighbour_t;

  neighbour_t               neighbour_q[$];
  logic [knn_pkg::ValW-1:0] row_mem [256][256];
  logic [knn_pkg::ValW-1:0] target_mem [256];
  logic [4:0]               k_reg;
  logic [8:0]               rows_reg;
  logic [8:0]               dims_reg;

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Brute-force nearest-row search over the rows and dims in use.
  task automatic find_nearest_rows();
    int                        k;
    int                        rows;
    int                        dims;
    int                        filled;
    int                        pos;
    logic [63:0]               acc;
    logic [63:0]               diff;
    logic [knn_pkg::DistW-1:0] best_d [16];
    logic [7:0]                best_r [16];
    neighbour_t                n;
    k = clamp(k_reg, 16);
    rows = clamp(rows_reg, 256);
    dims = clamp(dims_reg, 256);
    filled = 0;
    for (int r = 0; r < rows; r++) begin
      acc = 0;
      for (int d = 0; d < dims; d++) begin
        diff = (row_mem[r][d] >= target_mem[d]) ? row_mem[r][d] - target_mem[d]
                                                : target_mem[d] - row_mem[r][d];
        acc += diff * diff;
        if (acc > knn_pkg::DistMax) acc = knn_pkg::DistMax;
      end
      // Ties keep the earlier row ahead.
      pos = 0;
      while (pos < filled && best_d[pos] <= acc[knn_pkg::DistW-1:0]) pos++;
      if (pos < k) begin
        if (filled < k) filled++;
        for (int i = filled - 1; i > pos; i--) begin
          best_d[i] = best_d[i-1];
          best_r[i] = best_r[i-1];
        end
        best_d[pos] = acc[knn_pkg::DistW-1:0];
        best_r[pos] = r[7:0];
      end
    end
    for (int i = 0; i < filled; i++) begin
      n.rank    = i[3:0];
      n.row     = best_r[i];
      n.dist_sq = best_d[i];
      n.last    = (i + 1 == filled);
      neighbour_q.push_back(n);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    neighbour_t    exp_n;
    neighbour_t    got_n;
    knn_pkg::cmd_e cmd;
    if (!rst_ni) begin
      k_reg = 5'd1;
      rows_reg = 9'd256;
      dims_reg = 9'd256;
      neighbour_q.delete();
      mismatch_count = 0;
      pending_count = 0;
    end else begin
      // Register writes.
      if (cfg_we_i) begin
        case (knn_pkg::reg_e'(cfg_index_i))
          knn_pkg::REG_NEIGHBOURS: k_reg = cfg_data_i[4:0];
          knn_pkg::REG_ROWS:       rows_reg = cfg_data_i;
          knn_pkg::REG_DIMS:       dims_reg = cfg_data_i;
          default: ;
        endcase
      end
      // Result words against the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got_n = {m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tdata[51:12], m_axis_tlast};
        if (neighbour_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word: rank %0d row %0d dist %0d last %0b",
                   $time, got_n.rank, got_n.row, got_n.dist_sq, got_n.last);
        end else begin
          exp_n = neighbour_q.pop_front();
          if (got_n !== exp_n) begin
            mismatch_count++;
            $display("%0t: mismatch: expected rank %0d row %0d dist %0d last %0b",
                     $time, exp_n.rank, exp_n.row, exp_n.dist_sq, exp_n.last);
            $display("%0t:           actual rank %0d row %0d dist %0d last %0b",
                     $time, got_n.rank, got_n.row, got_n.dist_sq, got_n.last);
          end
        end
      end
      // Input words update the stores or start a search.
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = knn_pkg::cmd_e'(s_axis_tdata[1:0]);
        case (cmd)
          knn_pkg::CMD_TARGET: target_mem[s_axis_tdata[17:10]] = s_axis_tdata[33:18];
          knn_pkg::CMD_ROW:
            row_mem[s_axis_tdata[9:2]][s_axis_tdata[17:10]] = s_axis_tdata[33:18];
          knn_pkg::CMD_SEARCH: find_nearest_rows();
          default: ;
        endcase
      end
      pending_count = neighbour_q.size();
    end
  end

endmodule

/* dv/knn_euclidean_search_tb.sv */
`timescale 1ns / 1ps
// Top of the k-nearest-neighbor search testbench: clock, reset, stimulus,
// result stall and verdict. Depends on knn_pkg, the block and knn_search_checker.
module knn_euclidean_search_tb;

  localparam int IdleLimit = 40000;
  localparam int RandomWords = 80;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  int          mismatch_count;
  int          pending_count;
  int          words_sent;
  int          idle_cycles;
  bit          gaps_on;
  int          value_mode;

  knn_euclidean_search dut (.*);

  knn_search_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on cycles without any accepted word or register write.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("knn_euclidean_search verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each word.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  function automatic logic [15:0] pick_value(knn_pkg::cmd_e c);
    case (value_mode)
      1: return 16'($urandom_range(0, 2));
      2: return (c == knn_pkg::CMD_TARGET) ? 16'h0000 : 16'hFFFF;
      default: begin
        case ($urandom_range(0, 7))
          0: return 16'h0000;
          1: return 16'hFFFF;
          default: return 16'($urandom);
        endcase
      end
    endcase
  endfunction

  // Sends one word; called and returning at a falling edge.
  task automatic send_word(knn_pkg::cmd_e c, int row, int dim, logic [15:0] v);
    int gap;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {6'b0, v, dim[7:0], row[7:0], c};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // Register write once all results are out and the block has settled.
  task automatic write_reg(knn_pkg::reg_e idx, int val);
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val[8:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One setting: load every element in use, then a few searches with noise.
  task automatic run_setting(int k, int rows_raw, int dims_raw, int searches);
    int rows;
    int dims;
    int extra;
    rows = (rows_raw < 1) ? 1 : (rows_raw > 256 ? 256 : rows_raw);
    dims = (dims_raw < 1) ? 1 : (dims_raw > 256 ? 256 : dims_raw);
    write_reg(knn_pkg::REG_NEIGHBOURS, k);
    write_reg(knn_pkg::REG_ROWS, rows_raw);
    write_reg(knn_pkg::REG_DIMS, dims_raw);
    for (int d = 0; d < dims; d++) send_word(knn_pkg::CMD_TARGET, $urandom_range(0, 255), d,
                                             pick_value(knn_pkg::CMD_TARGET));
    for (int r = 0; r < rows; r++)
      for (int d = 0; d < dims; d++)
        send_word(knn_pkg::CMD_ROW, r, d, pick_value(knn_pkg::CMD_ROW));
    for (int s = 0; s < searches; s++) begin
      extra = $urandom_range(0, 3);
      for (int e = 0; e < extra; e++) begin
        case ($urandom_range(0, 3))
          0: send_word(knn_pkg::CMD_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                       16'($urandom));
          1: send_word(knn_pkg::CMD_TARGET, 0, $urandom_range(0, dims - 1),
                       pick_value(knn_pkg::CMD_TARGET));
          2: send_word(knn_pkg::CMD_ROW, $urandom_range(0, rows - 1),
                       $urandom_range(0, dims - 1), pick_value(knn_pkg::CMD_ROW));
          default: send_word(knn_pkg::CMD_ROW, $urandom_range(0, 255), $urandom_range(0, 255),
                             pick_value(knn_pkg::CMD_ROW));
        endcase
      end
      send_word(knn_pkg::CMD_SEARCH, $urandom_range(0, 255), $urandom_range(0, 255),
                16'($urandom));
    end
  endtask

  initial begin
    int first_random;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = knn_pkg::REG_NEIGHBOURS;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    gaps_on = 1'b1;
    value_mode = 0;
    words_sent = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: clamped registers, ties over the full row count, large distance.
    run_setting(0, 3, 2, 2);
    run_setting(31, 0, 0, 2);
    value_mode = 1;
    run_setting(16, 511, 1, 2);
    value_mode = 2;
    run_setting(16, 1, 48, 1);
    value_mode = 0;

    // Random settings, all with small sizes.
    first_random = words_sent;
    while (words_sent - first_random < RandomWords) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      value_mode = ($urandom_range(0, 4) == 0) ? 1 : 0;
      run_setting($urandom_range(1, 16), $urandom_range(1, 12), $urandom_range(1, 6),
                  $urandom_range(1, 3));
    end

    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("knn_euclidean_search verification clean");
    end else begin
      $display("knn_euclidean_search verification failed");
    end
    $finish;
  end

endmodule
